// ----- hdl/f2c_pkg.sv -----
// Shared constants, types and arithmetic helpers for the Frenet-to-Cartesian pose block.
`default_nettype none
package f2c_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int CORDIC_STEPS = 24;

    localparam int SEG_AW  = $clog2(MAX_SEGMENTS);
    localparam int COEF_AW = SEG_AW + 3;
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W   = SEG_AW + 2;
    localparam int STEP_W  = $clog2(CORDIC_STEPS);
    localparam int CW      = 34;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [3:0] WS_START   = 4'd0;
    localparam logic [3:0] WS_FIRST_C = 4'd1;
    localparam logic [3:0] WS_LAST_C  = 4'd8;

    localparam logic signed [CW-1:0] Q28_PI      = 34'sd843314857;
    localparam logic signed [CW-1:0] Q28_HALF_PI = 34'sd421657428;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] Q30_ONE_W   = 34'sd1073741824;
    localparam logic signed [31:0]   Q30_ONE     = 32'sd1073741824;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    localparam logic signed [31:0] ATAN_LUT [16] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192
    };

    typedef struct packed {
        logic               req_type;
        logic [5:0]         seg_index;
        logic [3:0]         word_select;
        logic signed [63:0] word_value;
        logic signed [31:0] arc_pos;
        logic signed [31:0] lateral_offset;
        logic signed [31:0] heading_offset;
    } req_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] yaw;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
        logic [5:0]         segment_used;
        logic               before_start;
    } res_t;

    typedef struct packed {
        logic               start_we;
        logic               coef_we;
        logic [SEG_AW-1:0]  seg;
        logic [2:0]         word;
        logic signed [63:0] data;
    } seg_wr_t;

    typedef struct packed {
        logic start;
        logic vec;
    } cordic_cmd_t;

    function automatic logic signed [CW-1:0] atan_step(input logic [STEP_W-1:0] i);
        if (int'(i) < 16)
            return CW'(ATAN_LUT[i[3:0]]);
        else if (int'(i) <= 28)
            return $signed(CW'(1) << (28 - int'(i)));
        else
            return '0;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (32'd0 - 32'(v)) : 32'(v);
    endfunction

    function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return 32'(v);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/f2c_intf.sv -----
// Request and result channel interfaces.
`default_nettype none
interface f2c_req_if;
    import f2c_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface f2c_res_if;
    import f2c_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/f2c_seg_mem.sv -----
// Segment start and coefficient tables with registered read ports.
`default_nettype none
module f2c_seg_mem (
    input  logic                            clk,
    input  f2c_pkg::seg_wr_t                wr,
    input  logic [f2c_pkg::SEG_AW-1:0]      st_raddr,
    output logic signed [31:0]              st_rdata,
    input  logic [f2c_pkg::COEF_AW-1:0]     cf_raddr,
    output logic signed [63:0]              cf_rdata
);
    import f2c_pkg::*;

    logic signed [31:0] start_mem [MAX_SEGMENTS];
    logic signed [63:0] coef_mem [MAX_SEGMENTS * 8];

    always_ff @(posedge clk)
    begin
        if (wr.start_we)
            start_mem[wr.seg] <= wr.data[31:0];
        st_rdata <= start_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.coef_we)
            coef_mem[{wr.seg, wr.word}] <= wr.data;
        cf_rdata <= coef_mem[cf_raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/f2c_mul.sv -----
// Shared multiplier: coefficient times arc position and offset products over one 32x32 array.
`default_nettype none
module f2c_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [31:0] b,
    output logic               done,
    output logic signed [63:0] prod_cs,
    output logic signed [63:0] prod_frac
);
    import f2c_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HI   = 2'd1;
    localparam logic [1:0] PH_LO   = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]  ph_reg, ph_next;
    logic        done_reg;
    logic [63:0] mc_reg;
    logic [31:0] ms_reg;
    logic        neg_reg;
    logic [63:0] hi_reg, lo_reg;
    logic signed [63:0] cs_reg, frac_reg;

    logic [31:0] op_a;
    logic [63:0] prod;
    logic [63:0] r;
    logic [63:0] q;
    logic signed [63:0] cs_w, frac_w;

    assign op_a = (ph_reg == PH_HI) ? mc_reg[63:32] : mc_reg[31:0];
    assign prod = 64'(op_a) * 64'(ms_reg);
    assign r    = (hi_reg << 16) + (lo_reg >> 16);
    assign q    = lo_reg >> 30;

    always_comb
    begin
        if (hi_reg[63:47] != '0)
            cs_w = neg_reg ? S64_MIN : S64_MAX;
        else if (neg_reg)
            cs_w = r[63] ? S64_MIN : $signed(64'd0 - r);
        else
            cs_w = r[63] ? S64_MAX : $signed(r);
        frac_w = neg_reg ? $signed(64'd0 - q) : $signed(q);
    end

    always_comb
    begin
        ph_next = ph_reg;
        unique case (ph_reg)
            PH_IDLE: if (start) ph_next = PH_HI;
            PH_HI:   ph_next = PH_LO;
            PH_LO:   ph_next = PH_FIN;
            PH_FIN:  ph_next = PH_IDLE;
            default: ph_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= (ph_reg == PH_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ph_reg == PH_IDLE && start)
        begin
            mc_reg  <= mag64(a);
            ms_reg  <= mag32(b);
            neg_reg <= a[63] ^ b[31];
        end
        if (ph_reg == PH_HI)
            hi_reg <= prod;
        if (ph_reg == PH_LO)
            lo_reg <= prod;
        if (ph_reg == PH_FIN)
        begin
            cs_reg   <= cs_w;
            frac_reg <= frac_w;
        end
    end

    assign done      = done_reg;
    assign prod_cs   = cs_reg;
    assign prod_frac = frac_reg;
endmodule
`default_nettype wire

// ----- hdl/f2c_cordic.sv -----
// Shared CORDIC unit: vectoring for atan2, rotation for cosine and sine, one step a cycle.
`default_nettype none
module f2c_cordic (
    input  logic                   clk,
    input  logic                   rst_n,
    input  f2c_pkg::cordic_cmd_t   cmd,
    input  logic signed [63:0]     vec_x,
    input  logic signed [63:0]     vec_y,
    input  logic signed [31:0]     rot_z,
    output logic                   done,
    output logic signed [31:0]     angle,
    output logic signed [31:0]     cos_out,
    output logic signed [31:0]     sin_out
);
    import f2c_pkg::*;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_NORM = 3'd1;
    localparam logic [2:0] C_PREP = 3'd2;
    localparam logic [2:0] C_RED  = 3'd3;
    localparam logic [2:0] C_ITER = 3'd4;
    localparam logic [2:0] C_POST = 3'd5;

    logic [2:0]  cst_reg, cst_next;
    logic        done_reg, done_next;
    logic        vec_reg;
    logic [63:0] mx_reg, my_reg;
    logic        sx_reg, sy_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic        flip_reg;
    logic [STEP_W-1:0] i_reg;
    logic signed [31:0] angle_reg, cos_reg, sin_reg;

    logic [63:0] m_or;
    logic signed [CW-1:0] xs, ys, x_sh, y_sh, a_step, xr, yr;
    logic up;

    assign m_or   = mx_reg | my_reg;
    assign xs     = sx_reg ? $signed(CW'(0) - CW'(mx_reg)) : $signed(CW'(mx_reg));
    assign ys     = sy_reg ? $signed(CW'(0) - CW'(my_reg)) : $signed(CW'(my_reg));
    assign x_sh   = x_reg >>> i_reg;
    assign y_sh   = y_reg >>> i_reg;
    assign a_step = atan_step(i_reg);
    assign up     = vec_reg ? y_reg[CW-1] : !z_reg[CW-1];
    assign xr     = flip_reg ? -x_reg : x_reg;
    assign yr     = flip_reg ? -y_reg : y_reg;

    function automatic logic signed [31:0] clamp_unit(input logic signed [CW-1:0] v);
        if (v > Q30_ONE_W)
            return Q30_ONE;
        if (v < -Q30_ONE_W)
            return -Q30_ONE;
        return 32'(v);
    endfunction

    always_comb
    begin
        cst_next  = cst_reg;
        done_next = 1'b0;
        unique case (cst_reg)
            C_IDLE:
                if (cmd.start)
                begin
                    if (!cmd.vec)
                        cst_next = C_RED;
                    else if (vec_x == '0 && vec_y == '0)
                        done_next = 1'b1;
                    else
                        cst_next = C_NORM;
                end
            C_NORM:
                if (m_or[63:38] == '0 && m_or[63:30] == '0 && m_or[63:21] != '0
                    && m_or[63:29] != '0)
                    cst_next = C_PREP;
            C_PREP:
                cst_next = C_ITER;
            C_RED:
                if (!(z_reg > Q28_HALF_PI) && !(z_reg < -Q28_HALF_PI))
                    cst_next = C_ITER;
            C_ITER:
                if (i_reg == STEP_W'(CORDIC_STEPS - 1))
                    cst_next = C_POST;
            C_POST:
            begin
                cst_next  = C_IDLE;
                done_next = 1'b1;
            end
            default:
                cst_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cst_reg  <= C_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            cst_reg  <= cst_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cst_reg)
            C_IDLE:
                if (cmd.start)
                begin
                    vec_reg  <= cmd.vec;
                    mx_reg   <= mag64(vec_x);
                    my_reg   <= mag64(vec_y);
                    sx_reg   <= vec_x[63];
                    sy_reg   <= vec_y[63];
                    z_reg    <= CW'(rot_z);
                    x_reg    <= CORDIC_GAIN;
                    y_reg    <= '0;
                    flip_reg <= 1'b0;
                    i_reg    <= '0;
                    if (cmd.vec)
                        angle_reg <= '0;
                end
            C_NORM:
                // scale the larger magnitude into [2^29, 2^30)
                priority if (m_or[63:38] != '0)
                begin
                    mx_reg <= mx_reg >> 8;
                    my_reg <= my_reg >> 8;
                end
                else if (m_or[63:30] != '0)
                begin
                    mx_reg <= mx_reg >> 1;
                    my_reg <= my_reg >> 1;
                end
                else if (m_or[63:21] == '0)
                begin
                    mx_reg <= mx_reg << 8;
                    my_reg <= my_reg << 8;
                end
                else if (m_or[63:29] == '0)
                begin
                    mx_reg <= mx_reg << 1;
                    my_reg <= my_reg << 1;
                end
                else
                begin
                    mx_reg <= mx_reg;
                    my_reg <= my_reg;
                end
            C_PREP:
                // fold the left half plane onto the right
                if (xs[CW-1])
                begin
                    z_reg <= ys[CW-1] ? -Q28_PI : Q28_PI;
                    x_reg <= -xs;
                    y_reg <= -ys;
                end
                else
                begin
                    z_reg <= '0;
                    x_reg <= xs;
                    y_reg <= ys;
                end
            C_RED:
                priority if (z_reg > Q28_HALF_PI)
                begin
                    z_reg    <= z_reg - Q28_PI;
                    flip_reg <= !flip_reg;
                end
                else if (z_reg < -Q28_HALF_PI)
                begin
                    z_reg    <= z_reg + Q28_PI;
                    flip_reg <= !flip_reg;
                end
                else
                    z_reg <= z_reg;
            C_ITER:
            begin
                if (up)
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - a_step;
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + a_step;
                end
                i_reg <= i_reg + STEP_W'(1);
            end
            C_POST:
                if (vec_reg)
                    angle_reg <= 32'(z_reg);
                else
                begin
                    cos_reg <= clamp_unit(xr);
                    sin_reg <= clamp_unit(yr);
                end
            default:
                vec_reg <= 1'b0;
        endcase
    end

    assign done    = done_reg;
    assign angle   = angle_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
endmodule
`default_nettype wire

// ----- hdl/frenet_to_cartesian_pose_top.sv -----
// Frenet-to-Cartesian pose converter over a table of cubic reference segments.
//
// A write request loads one word of one segment and gives no result. A query
// request is taken one at a time and runs through a bisection over the segment
// starts (each probe a read on the start table's port in S_SRCH and a compare
// in S_SCMP), a fetch of the eight coefficients, ten saturating multiply-adds
// on the shared multiplier, two offset products, and three passes of the
// shared CORDIC unit of CORDIC_STEPS steps each, plus its operand scaling and
// angle folding. The result sits in an output register, so the next request can
// be taken while a result waits. The segment tables have no reset. segment_count
// resets to 1; the user must write it only while idle, which the block does not enforce.
`default_nettype none
module frenet_to_cartesian_pose_top (
    input  logic        clk,
    input  logic        rst_n,
    f2c_req_if.sink     req,
    f2c_res_if.source   res,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data
);
    import f2c_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SRCH   = 5'd1;
    localparam logic [4:0] S_SCMP   = 5'd2;
    localparam logic [4:0] S_SFIN   = 5'd3;
    localparam logic [4:0] S_LOAD   = 5'd4;
    localparam logic [4:0] S_PINIT  = 5'd5;
    localparam logic [4:0] S_PINIT3 = 5'd6;
    localparam logic [4:0] S_PMUL   = 5'd7;
    localparam logic [4:0] S_PWAIT  = 5'd8;
    localparam logic [4:0] S_ATAN   = 5'd9;
    localparam logic [4:0] S_AWAIT  = 5'd10;
    localparam logic [4:0] S_ROT1   = 5'd11;
    localparam logic [4:0] S_R1WAIT = 5'd12;
    localparam logic [4:0] S_OFS1   = 5'd13;
    localparam logic [4:0] S_O1WAIT = 5'd14;
    localparam logic [4:0] S_OFS2   = 5'd15;
    localparam logic [4:0] S_O2WAIT = 5'd16;
    localparam logic [4:0] S_ROT2   = 5'd17;
    localparam logic [4:0] S_R2WAIT = 5'd18;
    localparam logic [4:0] S_OUT    = 5'd19;

    logic [4:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   ov_reg, ov_next;
    res_t                   out_reg, out_next;

    logic signed [31:0]     s_reg, s_next;
    logic signed [31:0]     rho_reg, rho_next;
    logic signed [31:0]     hdg_reg, hdg_next;
    logic signed [IDX_W-1:0] head_reg, head_next, tail_reg, tail_next, mid_reg, mid_next;
    logic [SEG_AW-1:0]      seg_reg, seg_next;
    logic                   before_reg, before_next;
    logic [3:0]             ld_reg, ld_next;
    logic signed [63:0]     coef_reg [8];
    logic signed [63:0]     coef_next [8];
    logic signed [63:0]     d2_reg, d2_next;
    logic signed [63:0]     acc_reg, acc_next;
    logic [1:0]             poly_reg, poly_next;
    logic [1:0]             term_reg, term_next;
    logic signed [63:0]     pv_reg [4];
    logic signed [63:0]     pv_next [4];
    logic signed [48:0]     xq_reg, xq_next, yq_reg, yq_next;
    logic signed [31:0]     theta_reg, theta_next, yaw_reg, yaw_next;
    logic signed [31:0]     ct_reg, ct_next, st_reg, st_next;
    logic signed [31:0]     px_reg, px_next, py_reg, py_next;

    logic                   req_acc;
    logic                   idx_ok;
    seg_wr_t                wr;
    logic [SEG_AW-1:0]      st_raddr;
    logic signed [31:0]     st_rdata;
    logic [COEF_AW-1:0]     cf_raddr;
    logic signed [63:0]     cf_rdata;
    logic signed [IDX_W:0]  mid_sum;
    logic signed [IDX_W-1:0] mid_w;

    logic                   mul_start;
    logic signed [63:0]     mul_a;
    logic signed [31:0]     mul_b;
    logic                   mul_done;
    logic signed [63:0]     prod_cs, prod_frac;

    cordic_cmd_t            ccmd;
    logic signed [31:0]     c_z;
    logic                   c_done;
    logic signed [31:0]     c_angle, c_cos, c_sin;

    logic signed [63:0]     k3, k2, k1, k0, addend, mac;
    logic                   last_term;

    function automatic logic signed [48:0] tdiv16(input logic signed [63:0] v);
        logic [63:0] m;
        logic [47:0] q;
        m = mag64(v);
        q = 48'(m >> 16);
        return v[63] ? $signed(49'd0 - 49'(q)) : $signed(49'(q));
    endfunction

    assign req_acc   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign res.valid = ov_reg;
    assign res.data  = out_reg;

    assign idx_ok       = int'(req.data.seg_index) < MAX_SEGMENTS;
    assign wr.start_we  = req_acc && req.data.req_type == REQ_WRITE && idx_ok
                          && req.data.word_select == WS_START;
    assign wr.coef_we   = req_acc && req.data.req_type == REQ_WRITE && idx_ok
                          && req.data.word_select >= WS_FIRST_C
                          && req.data.word_select <= WS_LAST_C;
    assign wr.seg       = SEG_AW'(req.data.seg_index);
    assign wr.word      = 3'(req.data.word_select - WS_FIRST_C);
    assign wr.data      = req.data.word_value;

    assign mid_sum = (IDX_W + 1)'(head_reg) + (IDX_W + 1)'(tail_reg);
    assign mid_w   = IDX_W'(mid_sum >>> 1);
    assign cf_raddr = {seg_reg, ld_reg[2:0]};

    f2c_seg_mem u_mem (
        .clk      (clk),
        .wr       (wr),
        .st_raddr (st_raddr),
        .st_rdata (st_rdata),
        .cf_raddr (cf_raddr),
        .cf_rdata (cf_rdata)
    );

    // cubic terms for x/y or their slopes, picked by the poly index
    assign k3 = poly_reg[0] ? coef_reg[7] : coef_reg[3];
    assign k2 = poly_reg[0] ? coef_reg[6] : coef_reg[2];
    assign k1 = poly_reg[0] ? coef_reg[5] : coef_reg[1];
    assign k0 = poly_reg[0] ? coef_reg[4] : coef_reg[0];

    always_comb
    begin
        if (!poly_reg[1])
        begin
            last_term = (term_reg == 2'd2);
            unique case (term_reg)
                2'd0:    addend = k2;
                2'd1:    addend = k1;
                default: addend = k0;
            endcase
        end
        else
        begin
            last_term = (term_reg == 2'd1);
            addend    = (term_reg == 2'd0) ? d2_reg : k1;
        end
    end

    assign mac = add_sat64(prod_cs, addend);

    assign mul_start = (state_reg == S_PMUL) || (state_reg == S_OFS1)
                       || (state_reg == S_OFS2);
    assign mul_a     = (state_reg == S_OFS1) ? 64'(st_reg)
                     : (state_reg == S_OFS2) ? 64'(ct_reg) : acc_reg;
    assign mul_b     = (state_reg == S_PMUL) ? s_reg : rho_reg;

    f2c_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mul_start),
        .a         (mul_a),
        .b         (mul_b),
        .done      (mul_done),
        .prod_cs   (prod_cs),
        .prod_frac (prod_frac)
    );

    assign ccmd.start = (state_reg == S_ATAN) || (state_reg == S_ROT1)
                        || (state_reg == S_ROT2);
    assign ccmd.vec   = (state_reg == S_ATAN);
    assign c_z        = (state_reg == S_ROT1) ? theta_reg : (yaw_reg >>> 1);

    f2c_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ccmd),
        .vec_x   (pv_reg[2]),
        .vec_y   (pv_reg[3]),
        .rot_z   (c_z),
        .done    (c_done),
        .angle   (c_angle),
        .cos_out (c_cos),
        .sin_out (c_sin)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ov_next     = ov_reg && !res.ready;
        out_next    = out_reg;
        s_next      = s_reg;
        rho_next    = rho_reg;
        hdg_next    = hdg_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        mid_next    = mid_reg;
        seg_next    = seg_reg;
        before_next = before_reg;
        ld_next     = ld_reg;
        coef_next   = coef_reg;
        d2_next     = d2_reg;
        acc_next    = acc_reg;
        poly_next   = poly_reg;
        term_next   = term_reg;
        pv_next     = pv_reg;
        xq_next     = xq_reg;
        yq_next     = yq_reg;
        theta_next  = theta_reg;
        yaw_next    = yaw_reg;
        ct_next     = ct_reg;
        st_next     = st_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        st_raddr    = SEG_AW'(head_reg);

        if (cfg_we)
        begin
            priority if (cfg_data == '0)
                cnt_next = CNT_W'(1);
            else if (int'(cfg_data) > MAX_SEGMENTS)
                cnt_next = CNT_W'(MAX_SEGMENTS);
            else
                cnt_next = CNT_W'(cfg_data);
        end

        unique case (state_reg)
            S_IDLE:
                if (req_acc && req.data.req_type == REQ_QUERY)
                begin
                    s_next      = req.data.arc_pos;
                    rho_next    = req.data.lateral_offset;
                    hdg_next    = req.data.heading_offset;
                    head_next   = '0;
                    tail_next   = $signed(IDX_W'(cnt_reg) - IDX_W'(1));
                    before_next = 1'b0;
                    state_next  = S_SRCH;
                end
            S_SRCH:
                if (head_reg < tail_reg)
                begin
                    mid_next   = mid_w;
                    st_raddr   = SEG_AW'(mid_w);
                    state_next = S_SCMP;
                end
                else
                    state_next = S_SFIN;
            S_SCMP:
            begin
                priority if (st_rdata < s_reg)
                begin
                    head_next  = mid_reg + IDX_W'(1);
                    state_next = S_SRCH;
                end
                else if (s_reg < st_rdata)
                begin
                    tail_next  = mid_reg - IDX_W'(1);
                    state_next = S_SRCH;
                end
                else
                begin
                    seg_next   = SEG_AW'(mid_reg);
                    ld_next    = '0;
                    state_next = S_LOAD;
                end
            end
            S_SFIN:
            begin
                // below the first start: fall back to segment 0 and flag it
                if (s_reg < st_rdata)
                begin
                    if (head_reg == '0)
                    begin
                        seg_next    = '0;
                        before_next = 1'b1;
                    end
                    else
                        seg_next = SEG_AW'(head_reg - IDX_W'(1));
                end
                else
                    seg_next = SEG_AW'(head_reg);
                ld_next    = '0;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (ld_reg != '0)
                    coef_next[3'(ld_reg - 4'd1)] = cf_rdata;
                ld_next = ld_reg + 4'd1;
                if (ld_reg == 4'd8)
                begin
                    poly_next  = '0;
                    state_next = S_PINIT;
                end
            end
            S_PINIT:
            begin
                term_next = '0;
                if (!poly_reg[1])
                begin
                    acc_next   = k3;
                    state_next = S_PMUL;
                end
                else
                begin
                    acc_next   = add_sat64(k3, k3);
                    d2_next    = add_sat64(k2, k2);
                    state_next = S_PINIT3;
                end
            end
            S_PINIT3:
            begin
                acc_next   = add_sat64(acc_reg, k3);
                state_next = S_PMUL;
            end
            S_PMUL:
                state_next = S_PWAIT;
            S_PWAIT:
                if (mul_done)
                begin
                    acc_next = mac;
                    if (last_term)
                    begin
                        pv_next[poly_reg] = mac;
                        poly_next         = poly_reg + 2'd1;
                        state_next        = (poly_reg == 2'd3) ? S_ATAN : S_PINIT;
                    end
                    else
                    begin
                        term_next  = term_reg + 2'd1;
                        state_next = S_PMUL;
                    end
                end
            S_ATAN:
            begin
                xq_next    = tdiv16(pv_reg[0]);
                yq_next    = tdiv16(pv_reg[1]);
                state_next = S_AWAIT;
            end
            S_AWAIT:
                if (c_done)
                begin
                    theta_next = c_angle;
                    state_next = S_ROT1;
                end
            S_ROT1:
            begin
                yaw_next   = sat32(64'(theta_reg) + 64'(hdg_reg));
                state_next = S_R1WAIT;
            end
            S_R1WAIT:
                if (c_done)
                begin
                    ct_next    = c_cos;
                    st_next    = c_sin;
                    state_next = S_OFS1;
                end
            S_OFS1:
                state_next = S_O1WAIT;
            S_O1WAIT:
                if (mul_done)
                begin
                    px_next    = sat32(64'(xq_reg) - prod_frac);
                    state_next = S_OFS2;
                end
            S_OFS2:
                state_next = S_O2WAIT;
            S_O2WAIT:
                if (mul_done)
                begin
                    py_next    = sat32(64'(yq_reg) + prod_frac);
                    state_next = S_ROT2;
                end
            S_ROT2:
                state_next = S_R2WAIT;
            S_R2WAIT:
                if (c_done)
                    state_next = S_OUT;
            S_OUT:
                // hold until the output register is free
                if (!ov_reg || res.ready)
                begin
                    out_next.pos_x        = px_reg;
                    out_next.pos_y        = py_reg;
                    out_next.yaw          = yaw_reg;
                    out_next.quat_z       = c_sin;
                    out_next.quat_w       = c_cos;
                    out_next.segment_used = 6'(seg_reg);
                    out_next.before_start = before_reg;
                    ov_next               = 1'b1;
                    state_next            = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= CNT_W'(1);
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        s_reg      <= s_next;
        rho_reg    <= rho_next;
        hdg_reg    <= hdg_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        mid_reg    <= mid_next;
        seg_reg    <= seg_next;
        before_reg <= before_next;
        ld_reg     <= ld_next;
        coef_reg   <= coef_next;
        d2_reg     <= d2_next;
        acc_reg    <= acc_next;
        poly_reg   <= poly_next;
        term_reg   <= term_next;
        pv_reg     <= pv_next;
        xq_reg     <= xq_next;
        yq_reg     <= yq_next;
        theta_reg  <= theta_next;
        yaw_reg    <= yaw_next;
        ct_reg     <= ct_next;
        st_reg     <= st_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
    end
endmodule
`default_nettype wire

// ----- hdl/f2c_checker.sv -----
// Port-level checks for the pose converter, bound to the top level.
`default_nettype none
module f2c_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            req_type,
    input logic            res_valid,
    input logic            res_ready,
    input f2c_pkg::res_t   res_data
);
    import f2c_pkg::*;

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_QUERY |=> !req_ready)
        else $error("ready stayed high after a query request");

    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_WRITE |=> req_ready)
        else $error("write request left the block busy");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.quat_z <= Q30_ONE && res_data.quat_z >= -Q30_ONE
                      && res_data.quat_w <= Q30_ONE && res_data.quat_w >= -Q30_ONE)
        else $error("quaternion part out of unit range");

    a_before_seg: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.before_start |-> res_data.segment_used == '0)
        else $error("before_start set with nonzero segment");
endmodule

bind frenet_to_cartesian_pose_top f2c_checker u_f2c_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.data.req_type),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
`default_nettype wire
